/* hdl/stbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_pkg
// shared types, constants and helpers for the sorted table binary search
// ----------------------------------------------------------------------------
package stbs_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;
    localparam int KEY_W       = 32;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [IDX_W-1:0]        entry_index;
        logic signed [KEY_W-1:0] entry_value;
        logic signed [KEY_W-1:0] search_key;
    } in_item_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } out_item_t;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        waddr;
        logic signed [KEY_W-1:0] wdata;
        logic                    re;
        logic [IDX_W-1:0]        raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } search_state_t;

    // midpoint of [lo, hi), hi exclusive, only meaningful when lo < hi
    function automatic logic [IDX_W-1:0] mid_of(input logic [LEN_W-1:0] lo,
                                                input logic [LEN_W-1:0] hi);
        logic [LEN_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - (LEN_W+1)'(1);
        return sum[IDX_W:1];
    endfunction

endpackage
`default_nettype wire

/* hdl/stbs_key_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_key_ram
// key table, one write port and one registered read port
// ----------------------------------------------------------------------------
module stbs_key_ram (
    input  wire logic                             aclk,
    input  wire stbs_pkg::ram_req_t               ram_req,
    output logic signed [stbs_pkg::KEY_W-1:0]     ram_rdata
);
    import stbs_pkg::*;

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];
    logic signed [KEY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        if (ram_req.re) begin
            rdata_reg <= mem[ram_req.raddr];
        end
    end

    assign ram_rdata = rdata_reg;

endmodule
`default_nettype wire

/* hdl/stbs_search_fsm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stbs_search_fsm
// command decode and halving search over the key table
// ----------------------------------------------------------------------------
module stbs_search_fsm (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire stbs_pkg::in_item_t            s_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [stbs_pkg::LEN_W-1:0]    table_length,
    output stbs_pkg::ram_req_t                 ram_req,
    input  wire logic signed [stbs_pkg::KEY_W-1:0] ram_rdata,
    input  wire logic                          slot_free,
    output logic                               res_load,
    output stbs_pkg::out_item_t                res
);
    import stbs_pkg::*;

    search_state_t           state_reg, state_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0]        left_reg, left_next;
    logic [LEN_W-1:0]        hi_reg, hi_next;
    logic [IDX_W-1:0]        mid_reg, mid_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    logic [LEN_W-1:0] len_sat;
    logic             take_search;
    logic             take_write;
    logic             hit;
    logic             below;
    logic [LEN_W-1:0] step_left;
    logic [LEN_W-1:0] step_hi;
    logic             step_more;

    // clamp length to the table depth
    assign len_sat = (table_length > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                          : table_length;

    assign take_search = (state_reg == ST_IDLE) && s_valid && (s_data.cmd == CMD_SEARCH);
    assign take_write  = (state_reg == ST_IDLE) && s_valid && (s_data.cmd == CMD_WRITE);

    // probe compare against the entry read last cycle
    assign hit       = (ram_rdata == key_reg);
    assign below     = (ram_rdata < key_reg);
    assign step_left = below ? (LEN_W'(mid_reg) + LEN_W'(1)) : left_reg;
    assign step_hi   = below ? hi_reg : LEN_W'(mid_reg);
    assign step_more = !hit && (step_left < step_hi);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take_search) begin
                    state_next = (len_sat == '0) ? ST_EMIT : ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!step_more) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready       = 1'b0;
        res_load      = 1'b0;
        ram_req.we    = take_write;
        ram_req.waddr = s_data.entry_index;
        ram_req.wdata = s_data.entry_value;
        ram_req.re    = 1'b0;
        ram_req.raddr = mid_of(left_reg, hi_reg);
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                ram_req.re    = take_search && (len_sat != '0);
                ram_req.raddr = mid_of('0, len_sat);
            end
            ST_PROBE: begin
                ram_req.re    = step_more;
                ram_req.raddr = mid_of(step_left, step_hi);
            end
            ST_EMIT: begin
                res_load = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        key_next   = key_reg;
        left_next  = left_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        idx_next   = idx_reg;
        if (take_search) begin
            key_next   = s_data.search_key;
            left_next  = '0;
            hi_next    = len_sat;
            mid_next   = mid_of('0, len_sat);
            found_next = 1'b0;
            idx_next   = '0;
        end else if (state_reg == ST_PROBE) begin
            left_next = step_left;
            hi_next   = step_hi;
            mid_next  = mid_of(step_left, step_hi);
            if (hit) begin
                found_next = 1'b1;
                idx_next   = mid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        left_reg  <= left_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
    end

    assign res.found       = found_reg;
    assign res.match_index = idx_reg;

endmodule
`default_nettype wire

/* hdl/sorted_table_binary_search.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// table of signed 32-bit keys, loaded by write items, searched by halving
// ----------------------------------------------------------------------------
// The table holds 64 signed keys in one synchronous memory. A write transfer
// (cmd = write) stores entry_value at entry_index and gives no result. A
// search transfer (cmd = search) looks up search_key over the first
// table_length entries (clamped to 64), which software keeps in ascending
// order, and gives one result: found with the index, or found = 0 and index 0.
// Steps: a search makes k probes, at most 7 for a full table and none for an
// empty one. It accepts the item and issues the first read; each probe
// compares the data of the registered memory read port and issues the next
// read; then the result moves into the output register once that register
// is free. The block takes no new item during a search. The output register
// lets a write or a new search be accepted while a result still waits on
// m_ready. table_length is written through the cfg port; the user must write
// it only while the block is idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sorted_table_binary_search (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input items
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire stbs_pkg::in_item_t           s_data,
    // results
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output stbs_pkg::out_item_t               m_data,
    // table_length register
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [stbs_pkg::LEN_W-1:0]   cfg_data
);
    import stbs_pkg::*;

    // configuration register
    logic [LEN_W-1:0] table_length_reg, table_length_next;

    // memory request from the sequencer, data back from the registered read port in the cycle after
    ram_req_t                ram_req;
    logic signed [KEY_W-1:0] ram_rdata;

    // result handoff into the output register
    logic      slot_free;
    logic      res_load;
    out_item_t res;

    // output register
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    // cfg_ready is tied high, so the register write is always accepted
    assign cfg_ready = 1'b1;

    always_comb begin
        table_length_next = table_length_reg;
        if (cfg_valid && cfg_ready) begin
            table_length_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else begin
            table_length_reg <= table_length_next;
        end
    end

    stbs_key_ram u_key_ram (
        .aclk      (aclk),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    stbs_search_fsm u_search_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_data       (s_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .table_length (table_length_reg),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .slot_free    (slot_free),
        .res_load     (res_load),
        .res          (res)
    );

    // output slot is free when empty or being drained this cycle
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // the memory never sees a write and a probe read in the same cycle
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.we && ram_req.re))
        else $error("key table written and read in the same cycle");

    // a probe read means a search is under way, so no item is taken next cycle
    a_busy_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.re |=> !s_ready)
        else $error("item accepted while a probe is outstanding");

    // a miss always reports index zero
    a_miss_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |-> (m_data.match_index == '0))
        else $error("miss result with nonzero index");

    // a loaded result is presented on the next cycle
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> (m_valid && (m_data == $past(res))))
        else $error("result not moved into the output register");
`endif

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted table binary search block
// ----------------------------------------------------------------------------
// Drives write and search transfers over the input channel and table_length
// over the config channel. A scoreboard keeps its own copy of the key table
// and the length, predicts every lookup by halving, and compares each result
// transfer field by field in order. The table is fully loaded before the first
// probing search, so no never-written entry is read. Random blocks load a
// sorted table (often with duplicates and the key extremes), run searches for
// present, neighboring, extreme and random keys, and mix in stray writes that
// leave the table unsorted. Both sides idle at random, and the receiver once
// stalls for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
    import stbs_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;
    localparam int N_RANDOM      = 750;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // keeps the key table and length, predicts lookups, checks results
    class lookup_checker;
        logic signed [KEY_W-1:0] key_copy [TABLE_DEPTH];
        logic [LEN_W-1:0]        length_copy;
        out_item_t               pending_lookups [$];
        int                      mismatches;

        function new();
            foreach (key_copy[i]) key_copy[i] = '0;
            length_copy = '0;
            mismatches  = 0;
        endfunction

        function void set_length(input logic [LEN_W-1:0] len);
            length_copy = len;
        endfunction

        function out_item_t predict_lookup(input logic signed [KEY_W-1:0] key);
            int        lo;
            int        hi;
            int        mid;
            out_item_t res;
            res = '0;
            lo  = 0;
            hi  = int'(length_copy);
            if (hi > TABLE_DEPTH) hi = TABLE_DEPTH;
            hi = hi - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (key_copy[mid] == key) begin
                    res.found       = 1'b1;
                    res.match_index = IDX_W'(mid);
                    break;
                end
                if (key_copy[mid] < key) lo = mid + 1;
                else hi = mid - 1;
            end
            return res;
        endfunction

        function void note_transfer(input in_item_t it);
            if (it.cmd == CMD_WRITE) begin
                key_copy[it.entry_index] = it.entry_value;
            end else begin
                pending_lookups.push_back(predict_lookup(it.search_key));
            end
        endfunction

        function void check_lookup(input out_item_t got);
            out_item_t want;
            if (pending_lookups.size() == 0) begin
                $error("unexpected result: found %0d, match_index %0d",
                       got.found, got.match_index);
                mismatches++;
                return;
            end
            want = pending_lookups.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.match_index !== want.match_index) begin
                $error("match_index: expected %0d, actual %0d",
                       want.match_index, got.match_index);
                mismatches++;
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_item_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_item_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data  = '0;

    lookup_checker sb = new();

    int tx_idle_pct = 25;
    int rx_idle_pct = 74;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;
    int rand_items = 0;

    sorted_table_binary_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // run limit, counted in cycles
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check every transfer, random backpressure, one long hold
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_lookup(m_data);
            results_seen++;
        end
        // start the long hold while the sender is offering
        if (!hold_done && results_seen >= HOLD_AT && s_valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // input item builders, unused fields get random content
    function automatic in_item_t write_item(input logic [IDX_W-1:0] idx,
                                            input logic signed [KEY_W-1:0] val);
        in_item_t it;
        it.cmd         = CMD_WRITE;
        it.entry_index = idx;
        it.entry_value = val;
        it.search_key  = $urandom;
        return it;
    endfunction

    function automatic in_item_t search_item(input logic signed [KEY_W-1:0] key);
        in_item_t it;
        it.cmd         = CMD_SEARCH;
        it.entry_index = IDX_W'($urandom);
        it.entry_value = $urandom;
        it.search_key  = key;
        return it;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input in_item_t it);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_transfer(it);
    endtask

    // stop offering, wait for every lookup to come back, then let the block go quiet
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_lookups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_length(len);
    endtask

    // ascending keys into entries 0..n-1, spread 0 steps give duplicates
    task automatic load_table(input int n, input int spread);
        longint v;
        longint top;
        longint val;
        bit     ends;
        top  = 64'sd4294967295 - 64 * longint'(spread);
        v    = longint'($urandom_range(32'(top), 0)) - 64'sd2147483648;
        ends = ($urandom_range(3) == 0);
        for (int i = 0; i < n; i++) begin
            val = v;
            if (ends && i == 0) val = KEY_MIN;
            if (ends && i == n - 1 && n > 1) val = KEY_MAX;
            send_item(write_item(IDX_W'(i), KEY_W'(val)));
            v = v + $urandom_range(spread, 0);
        end
    endtask

    // keys present in the table, their neighbors, the extremes and noise
    function automatic logic signed [KEY_W-1:0] pick_key(input int n);
        int r;
        int j;
        r = $urandom_range(99);
        j = (n > 0) ? $urandom_range(n - 1, 0) : 0;
        if (n > 0 && r < 50) return sb.key_copy[j];
        if (n > 0 && r < 70) return sb.key_copy[j] + ($urandom_range(1) ? 1 : -1);
        if (r < 85) return $urandom_range(1) ? KEY_MAX : KEY_MIN;
        return $urandom;
    endfunction

    initial begin
        int n;
        int r;
        int spread;
        int len;
        int nsearch;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, nothing is probed
        write_length(LEN_W'(0));
        send_item(search_item(KEY_MIN));
        send_item(search_item(0));

        // full load with both key extremes at the ends
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == 0) send_item(write_item(IDX_W'(i), KEY_MIN));
            else if (i == TABLE_DEPTH - 1) send_item(write_item(IDX_W'(i), KEY_MAX));
            else send_item(write_item(IDX_W'(i), i * 1000 - 31000));
        end

        // full length: ends, first probe hit, misses between keys
        write_length(LEN_W'(TABLE_DEPTH));
        send_item(search_item(KEY_MIN));
        send_item(search_item(KEY_MAX));
        send_item(search_item(0));
        send_item(search_item(5));
        send_item(search_item(9000));
        send_item(search_item(-1));

        // length above the depth saturates
        write_length(7'd127);
        send_item(search_item(KEY_MAX));
        send_item(search_item(-14000));

        // single entry table
        write_length(LEN_W'(1));
        send_item(search_item(KEY_MIN));
        send_item(search_item(KEY_MAX));

        // duplicates: first equal key in midpoint order wins
        write_length(LEN_W'(4));
        for (int i = 0; i < 4; i++) send_item(write_item(IDX_W'(i), 5));
        send_item(search_item(5));

        // unsorted table, probes run the same way
        send_item(write_item(IDX_W'(2), -100));
        send_item(search_item(-100));

        // random blocks: sorted load then searches, with stray writes
        while (rand_items < N_RANDOM) begin
            if (rand_items < N_RANDOM / 3) begin
                tx_idle_pct = 25;
                rx_idle_pct = 74;
            end else if (rand_items < 2 * N_RANDOM / 3) begin
                tx_idle_pct = 74;
                rx_idle_pct = 25;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            r = $urandom_range(99);
            if (r < 8) len = 0;
            else if (r < 18) len = TABLE_DEPTH;
            else if (r < 22) len = $urandom_range(127, TABLE_DEPTH + 1);
            else if (r < 28) len = 1;
            else len = $urandom_range(TABLE_DEPTH - 1, 2);
            write_length(LEN_W'(len));
            n = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;

            case ($urandom_range(3))
                0: spread = 2;
                1: spread = 1000;
                2: spread = 1 << 20;
                default: spread = 1 << 25;
            endcase
            load_table(n, spread);
            rand_items += n;

            nsearch = $urandom_range(40, 8);
            repeat (nsearch) begin
                if ($urandom_range(99) < 12) begin
                    send_item(write_item(IDX_W'($urandom), $urandom));
                end else begin
                    send_item(search_item(pick_key(n)));
                end
                rand_items++;
            end
        end

        settle();
        if (sb.pending_lookups.size() != 0) begin
            $error("%0d lookups never answered", sb.pending_lookups.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/stbs_pkg.sv
hdl/stbs_key_ram.sv
hdl/stbs_search_fsm.sv
hdl/sorted_table_binary_search.sv
tb/sv/tb_top.sv
